// File: hdl/dhd_pkg.sv
package dhd_pkg;

	localparam int SYM_NUM   = 12;
	localparam int SYM_W     = 2;
	localparam int SYMBOLS_W = SYM_NUM * SYM_W;
	localparam int LENGTH_W  = 4;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_FIND   = 1'b1
	} op_t;

	function automatic logic [63:0] pow5(input int n);
		logic [63:0] p;
		p = 64'd1;
		for (int k = 0; k < n; k++) begin
			p = p * 64'd5;
		end
		return p;
	endfunction

	// bits needed to hold every value below v
	function automatic int clog2_64(input logic [63:0] v);
		int r;
		r = 0;
		for (int k = 0; k < 64; k++) begin
			if ((64'd1 << r) < v) begin
				r = r + 1;
			end
		end
		return r;
	endfunction

	function automatic int key_width(input int max_symbols);
		return clog2_64(pow5(max_symbols));
	endfunction

	// contribution of symbol code d at place i to the key
	function automatic logic [63:0] key_term(input int i, input int d);
		return 64'(d + 1) * pow5(i);
	endfunction

	// same contribution reduced modulo m
	function automatic logic [63:0] mod_term(input int i, input int d, input logic [63:0] m);
		logic [63:0] p;
		logic [63:0] x;
		p = 64'd1;
		if (p >= m) begin
			p = p - m;
		end
		for (int k = 0; k < i; k++) begin
			p = p * 64'd5;
			for (int j = 0; j < 4; j++) begin
				if (p >= m) begin
					p = p - m;
				end
			end
		end
		x = 64'(d + 1) * p;
		for (int j = 0; j < 3; j++) begin
			if (x >= m) begin
				x = x - m;
			end
		end
		return x;
	endfunction

endpackage

// File: hdl/dhd_ram.sv
module dhd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hdl/dhd_fifo.sv
module dhd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = buf_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: hdl/dhd_front.sv
module dhd_front #(
	parameter int TABLE_SIZE = 4093,
	parameter int MAX_SYMBOLS = 12,
	localparam int KEY_W = dhd_pkg::key_width(MAX_SYMBOLS),
	localparam int POS_W = $clog2(TABLE_SIZE)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         enable,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic [dhd_pkg::SYMBOLS_W-1:0] symbols,
	input  logic [dhd_pkg::LENGTH_W-1:0]  length,
	output logic                         q_valid,
	input  logic                         q_ready,
	output logic                         q_op,
	output logic [KEY_W-1:0]             q_key,
	output logic [POS_W-1:0]             q_pos,
	output logic [POS_W-1:0]             q_step
);

	import dhd_pkg::*;

	localparam int NS = MAX_SYMBOLS;

	logic                vld_s [NS];
	logic                op_s  [NS];
	logic [SYMBOLS_W-1:0] sym_s [NS];
	logic [LENGTH_W-1:0] len_s [NS];
	logic [KEY_W-1:0]    key_s [NS];
	logic [POS_W-1:0]    pos_s [NS];
	logic [POS_W-1:0]    stp_s [NS];
	logic                adv;

	assign adv      = !vld_s[NS-1] || q_ready;
	assign in_ready = adv && enable;

	for (genvar i = 0; i < NS; i++) begin : g_stage
		localparam logic [3:0][KEY_W-1:0] KT = {
			KEY_W'(key_term(i, 3)), KEY_W'(key_term(i, 2)),
			KEY_W'(key_term(i, 1)), KEY_W'(key_term(i, 0))};
		localparam logic [3:0][POS_W-1:0] PT = {
			POS_W'(mod_term(i, 3, 64'(TABLE_SIZE))), POS_W'(mod_term(i, 2, 64'(TABLE_SIZE))),
			POS_W'(mod_term(i, 1, 64'(TABLE_SIZE))), POS_W'(mod_term(i, 0, 64'(TABLE_SIZE)))};
		localparam logic [3:0][POS_W-1:0] ST = {
			POS_W'(mod_term(i, 3, 64'(TABLE_SIZE - 1))),
			POS_W'(mod_term(i, 2, 64'(TABLE_SIZE - 1))),
			POS_W'(mod_term(i, 1, 64'(TABLE_SIZE - 1))),
			POS_W'(mod_term(i, 0, 64'(TABLE_SIZE - 1)))};

		logic                 vld_in;
		logic                 op_in;
		logic [SYMBOLS_W-1:0] sym_in;
		logic [LENGTH_W-1:0]  len_in;
		logic [KEY_W-1:0]     key_in;
		logic [POS_W-1:0]     pos_in;
		logic [POS_W-1:0]     stp_in;
		logic [SYM_W-1:0]     dig;
		logic                 act;
		logic [KEY_W-1:0]     key_nxt;
		logic [POS_W:0]       pos_sum;
		logic [POS_W:0]       stp_sum;
		logic [POS_W-1:0]     pos_nxt;
		logic [POS_W-1:0]     stp_nxt;

		if (i == 0) begin : g_first
			assign vld_in = in_valid && in_ready;
			assign op_in  = operation;
			assign sym_in = symbols;
			assign len_in = length;
			assign key_in = '0;
			assign pos_in = '0;
			assign stp_in = '0;
		end else begin : g_next
			assign vld_in = vld_s[i-1];
			assign op_in  = op_s[i-1];
			assign sym_in = sym_s[i-1];
			assign len_in = len_s[i-1];
			assign key_in = key_s[i-1];
			assign pos_in = pos_s[i-1];
			assign stp_in = stp_s[i-1];
		end

		if (i < SYM_NUM) begin : g_dig
			assign dig = sym_in[SYM_W*i +: SYM_W];
		end else begin : g_pad
			assign dig = '0;
		end

		// symbols past the length add nothing
		assign act     = (int'(len_in) > i);
		assign key_nxt = key_in + (act ? KT[dig] : '0);
		assign pos_sum = {1'b0, pos_in} + {1'b0, (act ? PT[dig] : POS_W'(0))};
		assign stp_sum = {1'b0, stp_in} + {1'b0, (act ? ST[dig] : POS_W'(0))};
		assign pos_nxt = (pos_sum >= (POS_W+1)'(TABLE_SIZE))
			? POS_W'(pos_sum - (POS_W+1)'(TABLE_SIZE)) : POS_W'(pos_sum);
		assign stp_nxt = (stp_sum >= (POS_W+1)'(TABLE_SIZE - 1))
			? POS_W'(stp_sum - (POS_W+1)'(TABLE_SIZE - 1)) : POS_W'(stp_sum);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				op_s[i]  <= op_in;
				sym_s[i] <= sym_in;
				len_s[i] <= len_in;
				key_s[i] <= key_nxt;
				pos_s[i] <= pos_nxt;
				stp_s[i] <= stp_nxt;
			end
		end
	end

	assign q_valid = vld_s[NS-1];
	assign q_op    = op_s[NS-1];
	assign q_key   = key_s[NS-1];
	assign q_pos   = pos_s[NS-1];
	assign q_step  = stp_s[NS-1] + 1'b1;

endmodule

// File: hdl/dhd_back.sv
module dhd_back #(
	parameter int TABLE_SIZE = 4093,
	parameter int MAX_SYMBOLS = 12,
	localparam int KEY_W = dhd_pkg::key_width(MAX_SYMBOLS),
	localparam int POS_W = $clog2(TABLE_SIZE)
) (
	input  logic             clk,
	input  logic             arst_n,
	output logic             clear_done,
	input  logic             q_valid,
	output logic             q_ready,
	input  logic             q_op,
	input  logic [KEY_W-1:0] q_key,
	input  logic [POS_W-1:0] q_pos,
	input  logic [POS_W-1:0] q_step,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             found,
	output logic             inserted,
	output logic             table_full
);

	import dhd_pkg::*;

	localparam int CNT_W = $clog2(TABLE_SIZE + 1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [POS_W-1:0] clr_q;
	logic [CNT_W-1:0] cnt_q;
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] step_q;
	logic             res_found_q;
	logic             res_ins_q;
	logic             res_full_q;
	logic             out_valid_q;
	logic             found_q;
	logic             inserted_q;
	logic             full_q;

	logic             wr_en;
	logic [POS_W-1:0] wr_addr;
	logic [KEY_W:0]   wr_data;
	logic             rd_en;
	logic [KEY_W:0]   rd_data;
	logic             slot_used;
	logic             hit;
	logic [CNT_W-1:0] cnt_nxt;
	logic [POS_W:0]   pos_sum;
	logic [POS_W-1:0] pos_nxt;

	// each word holds a used mark above the key
	dhd_ram #(
		.WIDTH(KEY_W + 1),
		.DEPTH(TABLE_SIZE)
	) u_slots (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(pos_q),
		.rd_data(rd_data)
	);

	assign slot_used = rd_data[KEY_W];
	assign hit       = slot_used && (rd_data[KEY_W-1:0] == key_q);
	assign cnt_nxt   = cnt_q + 1'b1;
	assign pos_sum   = {1'b0, pos_q} + {1'b0, step_q};
	assign pos_nxt   = (pos_sum >= (POS_W+1)'(TABLE_SIZE))
		? POS_W'(pos_sum - (POS_W+1)'(TABLE_SIZE)) : POS_W'(pos_sum);

	assign clear_done = (state_q != ST_CLEAR);
	assign q_ready    = (state_q == ST_IDLE);
	assign rd_en      = (state_q == ST_READ);
	assign wr_en      = (state_q == ST_CLEAR)
		|| ((state_q == ST_CHECK) && !slot_used && (op_q == OP_INSERT));
	assign wr_addr    = (state_q == ST_CLEAR) ? clr_q : pos_q;
	assign wr_data    = (state_q == ST_CLEAR) ? '0 : {1'b1, key_q};

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign inserted   = inserted_q;
	assign table_full = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == POS_W'(TABLE_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (q_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					cnt_q <= cnt_nxt;
					if (hit || !slot_used || (cnt_nxt == CNT_W'(TABLE_SIZE))) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			op_q   <= op_t'(q_op);
			key_q  <= q_key;
			pos_q  <= q_pos;
			step_q <= q_step;
		end
		if (state_q == ST_CHECK) begin
			res_found_q <= hit;
			res_ins_q   <= !slot_used && (op_q == OP_INSERT);
			res_full_q  <= slot_used && !hit && (cnt_nxt == CNT_W'(TABLE_SIZE));
			if (slot_used && !hit) begin
				pos_q <= pos_nxt;
			end
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			found_q    <= res_found_q;
			inserted_q <= res_ins_q;
			full_q     <= res_full_q;
		end
	end

endmodule

// File: hdl/double_hash_dictionary_top.sv
// Dictionary of nucleotide strings (A, C, G, T) in an open-addressed hash table with double
// hashing. Each item inserts or looks up a string of up to MAX_SYMBOLS symbols and returns
// one result: found, inserted, or table_full when TABLE_SIZE probes met neither the key nor
// an empty slot; a find that meets an empty slot sets none. After reset the block sweeps
// each slot, one entry per cycle, and holds in_ready low until the sweep is done. A
// MAX_SYMBOLS-stage front pipeline turns each string into its key, first slot and step,
// and feeds a two-entry queue. The back end probes through a single slot memory with
// registered read: for each item it goes from IDLE through a READ and a CHECK state per
// probe to DONE, and takes no new item until it is back in IDLE, so throughput is set by
// the probe count.
module double_hash_dictionary_top #(
	parameter int TABLE_SIZE = 4093,
	parameter int MAX_SYMBOLS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [dhd_pkg::SYMBOLS_W-1:0] symbols,
	input  logic [dhd_pkg::LENGTH_W-1:0]  length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic                          inserted,
	output logic                          table_full
);

	import dhd_pkg::*;

	localparam int KEY_W = key_width(MAX_SYMBOLS);
	localparam int POS_W = $clog2(TABLE_SIZE);
	localparam int FW    = 1 + KEY_W + 2 * POS_W;

	logic             clear_done;
	logic             f_valid;
	logic             f_ready;
	logic             f_op;
	logic [KEY_W-1:0] f_key;
	logic [POS_W-1:0] f_pos;
	logic [POS_W-1:0] f_step;
	logic [FW-1:0]    f_data;
	logic             b_valid;
	logic             b_ready;
	logic [FW-1:0]    b_data;
	logic             b_op;
	logic [KEY_W-1:0] b_key;
	logic [POS_W-1:0] b_pos;
	logic [POS_W-1:0] b_step;

	dhd_front #(
		.TABLE_SIZE (TABLE_SIZE),
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (clear_done),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.symbols  (symbols),
		.length   (length),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_op     (f_op),
		.q_key    (f_key),
		.q_pos    (f_pos),
		.q_step   (f_step)
	);

	assign f_data = {f_op, f_key, f_pos, f_step};

	dhd_fifo #(
		.WIDTH(FW),
		.DEPTH(2)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data (f_data),
		.rd_valid(b_valid),
		.rd_ready(b_ready),
		.rd_data (b_data)
	);

	assign {b_op, b_key, b_pos, b_step} = b_data;

	dhd_back #(
		.TABLE_SIZE (TABLE_SIZE),
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear_done(clear_done),
		.q_valid   (b_valid),
		.q_ready   (b_ready),
		.q_op      (b_op),
		.q_key     (b_key),
		.q_pos     (b_pos),
		.q_step    (b_step),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.inserted  (inserted),
		.table_full(table_full)
	);

endmodule
